// File: design/clt_pkg.sv
package clt_pkg;

  localparam int POSITION_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CHAR_W = 8;
  localparam int EV_KIND_W = 2;
  localparam int TOK_KIND_W = 3;
  localparam int POS_OUT_W = 16;
  localparam int RUN_MAX = 4;
  localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);
  localparam int RUN_IDX_W = $clog2(RUN_MAX);

  localparam logic [EV_KIND_W-1:0] EV_APPEND = 2'd0;
  localparam logic [EV_KIND_W-1:0] EV_CLOSE = 2'd1;
  localparam logic [EV_KIND_W-1:0] EV_ERROR = 2'd2;

  typedef struct packed {
    logic [EV_KIND_W-1:0] event_kind;
    logic [CHAR_W-1:0] token_char;
    logic [TOK_KIND_W-1:0] token_kind;
    logic [POS_OUT_W-1:0] start_line;
    logic [POS_OUT_W-1:0] start_column;
  } event_t;

  typedef struct packed {
    event_t [RUN_MAX-1:0] ev;
    logic [RUN_CNT_W-1:0] cnt;
  } run_t;

endpackage

// File: design/clt_front.sv
module clt_front #(
  parameter int POSITION_WIDTH = clt_pkg::POSITION_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [clt_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       q_full,
  output logic                       q_push,
  output clt_pkg::run_t              q_run
);

  localparam logic [3:0] MODE_IDLE = 4'd0;
  localparam logic [3:0] MODE_IDENT = 4'd1;
  localparam logic [3:0] MODE_NUMBER = 4'd2;
  localparam logic [3:0] MODE_COMMENT = 4'd3;
  localparam logic [3:0] MODE_STRING = 4'd4;
  localparam logic [3:0] MODE_CHARC = 4'd5;
  localparam logic [3:0] MODE_TWO = 4'd6;
  localparam logic [3:0] MODE_THREE = 4'd7;
  localparam logic [3:0] MODE_SLASH = 4'd8;
  localparam logic [3:0] MODE_ERROR = 4'd9;

  localparam logic [2:0] TK_IDENT = 3'd0;
  localparam logic [2:0] TK_NUMBER = 3'd1;
  localparam logic [2:0] TK_COMMENT = 3'd2;
  localparam logic [2:0] TK_STRING = 3'd3;
  localparam logic [2:0] TK_CHARC = 3'd4;
  localparam logic [2:0] TK_PUNCT = 3'd5;

  localparam logic [2:0] CL_OTHER = 3'd0;
  localparam logic [2:0] CL_WS = 3'd1;
  localparam logic [2:0] CL_LETTER = 3'd2;
  localparam logic [2:0] CL_DIGIT = 3'd3;
  localparam logic [2:0] CL_SINGLE = 3'd4;
  localparam logic [2:0] CL_TWO = 3'd5;
  localparam logic [2:0] CL_THREE = 3'd6;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
  localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);

  typedef struct packed {
    logic [3:0] mode;
    logic [2:0] kind;
    logic [7:0] first;
    logic [7:0] last;
    logic [1:0] plen;
    logic [POSITION_WIDTH-1:0] tline;
    logic [POSITION_WIDTH-1:0] tcol;
  } lex_st_t;

  lex_st_t st_r, st_nxt;
  logic [POSITION_WIDTH-1:0] line_r, line_nxt;
  logic [POSITION_WIDTH-1:0] col_r, col_nxt;
  clt_pkg::run_t run;
  logic [2:0] cl;
  logic idle_go;
  logic two_go;
  logic take;
  logic [7:0] c;

  function automatic logic [2:0] char_class(input logic [7:0] ch);
    logic [2:0] r;
    r = CL_OTHER;
    if (ch == 8'h00 || ch == " " || ch == CH_TAB || ch == CH_NL) begin
      r = CL_WS;
    end else if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")) begin
      r = CL_LETTER;
    end else if (ch >= "0" && ch <= "9") begin
      r = CL_DIGIT;
    end else if (ch == ":" || ch == "=" || ch == "+" || ch == "-" || ch == "|" ||
                 ch == "&" || ch == "!" || ch == "~" || ch == "%" || ch == "^" ||
                 ch == "*" || ch == "/") begin
      r = CL_TWO;
    end else if (ch == "<" || ch == ">") begin
      r = CL_THREE;
    end else if (ch == "(" || ch == ")" || ch == "{" || ch == "}" || ch == "[" ||
                 ch == "\\" || ch == ";" || ch == "?" || ch == "," || ch == ".") begin
      r = CL_SINGLE;
    end
    return r;
  endfunction

  function automatic logic [clt_pkg::POS_OUT_W-1:0] pos16(
    input logic [POSITION_WIDTH-1:0] p
  );
    logic [POSITION_WIDTH+clt_pkg::POS_OUT_W-1:0] w;
    w = {{clt_pkg::POS_OUT_W{1'b0}}, p};
    return w[clt_pkg::POS_OUT_W-1:0];
  endfunction

  function automatic void put_event(inout clt_pkg::run_t r,
                                    input logic [clt_pkg::EV_KIND_W-1:0] ek,
                                    input logic [7:0] ch,
                                    input logic [2:0] tk,
                                    input logic [POSITION_WIDTH-1:0] ln,
                                    input logic [POSITION_WIDTH-1:0] cn);
    clt_pkg::event_t e;
    e.event_kind = ek;
    e.token_char = ch;
    e.token_kind = tk;
    e.start_line = pos16(ln);
    e.start_column = pos16(cn);
    r.ev[r.cnt[clt_pkg::RUN_IDX_W-1:0]] = e;
    r.cnt = r.cnt + clt_pkg::RUN_CNT_W'(1);
  endfunction

  function automatic void do_append(inout lex_st_t s, inout clt_pkg::run_t r,
                                    input logic [7:0] ch);
    put_event(r, clt_pkg::EV_APPEND, ch, s.kind, s.tline, s.tcol);
    s.last = ch;
  endfunction

  function automatic void do_close(inout lex_st_t s, inout clt_pkg::run_t r);
    put_event(r, clt_pkg::EV_CLOSE, 8'h00, s.kind, s.tline, s.tcol);
    s.mode = MODE_IDLE;
  endfunction

  function automatic void do_open(inout lex_st_t s, input logic [2:0] k,
                                  input logic [3:0] m, input logic [7:0] ch,
                                  input logic [POSITION_WIDTH-1:0] ln,
                                  input logic [POSITION_WIDTH-1:0] cn);
    s.kind = k;
    s.mode = m;
    s.first = ch;
    s.plen = 2'd1;
    s.tline = ln;
    s.tcol = cn;
  endfunction

  assign c = in_char_code;
  assign cl = char_class(c);
  assign take = in_valid && !q_full;

  always_comb begin
    st_nxt = st_r;
    run = '0;
    idle_go = 1'b0;
    two_go = 1'b0;
    if (st_r.mode == MODE_ERROR) begin
      st_nxt = st_r;
    end else if (c[7]) begin
      put_event(run, clt_pkg::EV_ERROR, 8'h00, TK_IDENT, line_r, col_r);
      st_nxt.mode = MODE_ERROR;
    end else begin
      unique case (st_r.mode) inside
        MODE_IDENT: begin
          if (cl == CL_LETTER || cl == CL_DIGIT || c == "_") begin
            do_append(st_nxt, run, c);
          end else begin
            do_close(st_nxt, run);
            idle_go = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (cl == CL_DIGIT || c == "." || c == "x" || c == "X" ||
              (c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            do_append(st_nxt, run, c);
          end else begin
            do_close(st_nxt, run);
            idle_go = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NL) begin
            do_close(st_nxt, run);
          end else begin
            do_append(st_nxt, run, c);
          end
        end
        MODE_STRING, MODE_CHARC: begin
          if (c == ((st_r.mode == MODE_STRING) ? "\"" : "'") && st_r.last != "\\") begin
            do_append(st_nxt, run, c);
            do_close(st_nxt, run);
          end else if (c == CH_NL) begin
            do_close(st_nxt, run);
          end else begin
            do_append(st_nxt, run, c);
          end
        end
        MODE_SLASH: begin
          if (c == "/") begin
            st_nxt.kind = TK_COMMENT;
            st_nxt.mode = MODE_COMMENT;
            do_append(st_nxt, run, "/");
            do_append(st_nxt, run, c);
          end else begin
            do_append(st_nxt, run, "/");
            st_nxt.mode = MODE_TWO;
            two_go = 1'b1;
          end
        end
        MODE_TWO: begin
          two_go = 1'b1;
        end
        MODE_THREE: begin
          if (c == "=") begin
            do_append(st_nxt, run, c);
            do_close(st_nxt, run);
          end else if (c == st_r.first && st_r.plen == 2'd1) begin
            do_append(st_nxt, run, c);
            st_nxt.plen = 2'd2;
          end else begin
            do_close(st_nxt, run);
            idle_go = 1'b1;
          end
        end
        default: begin
          st_nxt.mode = MODE_IDLE;
          idle_go = 1'b1;
        end
      endcase

      if (two_go) begin
        if (((st_nxt.first == ":" || st_nxt.first == "=") && c == st_nxt.first) ||
            ((st_nxt.first == "+" || st_nxt.first == "-" || st_nxt.first == "|" ||
              st_nxt.first == "&") && (c == st_nxt.first || c == "=")) ||
            (!(st_nxt.first == ":" || st_nxt.first == "=" || st_nxt.first == "+" ||
               st_nxt.first == "-" || st_nxt.first == "|" || st_nxt.first == "&") &&
             c == "=")) begin
          do_append(st_nxt, run, c);
          do_close(st_nxt, run);
        end else begin
          do_close(st_nxt, run);
          idle_go = 1'b1;
        end
      end

      if (idle_go) begin
        if (cl == CL_WS) begin
          st_nxt.mode = MODE_IDLE;
        end else if (cl == CL_LETTER || c == "_") begin
          do_open(st_nxt, TK_IDENT, MODE_IDENT, c, line_r, col_r);
          do_append(st_nxt, run, c);
        end else if (cl == CL_DIGIT) begin
          do_open(st_nxt, TK_NUMBER, MODE_NUMBER, c, line_r, col_r);
          do_append(st_nxt, run, c);
        end else if (c == "/") begin
          do_open(st_nxt, TK_PUNCT, MODE_SLASH, c, line_r, col_r);
        end else if (c == "\"") begin
          do_open(st_nxt, TK_STRING, MODE_STRING, c, line_r, col_r);
          do_append(st_nxt, run, c);
        end else if (c == "'") begin
          do_open(st_nxt, TK_CHARC, MODE_CHARC, c, line_r, col_r);
          do_append(st_nxt, run, c);
        end else if (cl == CL_TWO) begin
          do_open(st_nxt, TK_PUNCT, MODE_TWO, c, line_r, col_r);
          do_append(st_nxt, run, c);
        end else if (cl == CL_THREE) begin
          do_open(st_nxt, TK_PUNCT, MODE_THREE, c, line_r, col_r);
          do_append(st_nxt, run, c);
        end else if (cl == CL_SINGLE) begin
          do_open(st_nxt, TK_PUNCT, MODE_IDLE, c, line_r, col_r);
          do_append(st_nxt, run, c);
          do_close(st_nxt, run);
        end else begin
          put_event(run, clt_pkg::EV_ERROR, 8'h00, TK_IDENT, line_r, col_r);
          st_nxt.mode = MODE_ERROR;
        end
      end
    end
  end

  always_comb begin
    line_nxt = line_r;
    col_nxt = col_r;
    if (st_r.mode != MODE_ERROR) begin
      if (c == CH_NL) begin
        if (line_r != POS_MAX) begin
          line_nxt = line_r + POS_ONE;
        end
        col_nxt = POS_ONE;
      end else if (col_r != POS_MAX) begin
        col_nxt = col_r + POS_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      line_r <= POS_ONE;
      col_r <= POS_ONE;
    end else if (take) begin
      st_r <= st_nxt;
      line_r <= line_nxt;
      col_r <= col_nxt;
    end
  end

  assign q_push = take && (run.cnt != '0);
  assign q_run = run;

endmodule

// File: design/clt_queue.sv
module clt_queue #(
  parameter int DEPTH = clt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  clt_pkg::run_t push_run,
  output logic          full,
  input  logic          pop,
  output clt_pkg::run_t head,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  clt_pkg::run_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic do_push, do_pop;

  assign full = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PTR_LAST) ? '0 : wr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == PTR_LAST) ? '0 : rd_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// File: design/clt_back.sv
module clt_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  clt_pkg::run_t                       head,
  input  logic                                empty,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [clt_pkg::EV_KIND_W-1:0]       out_event_kind,
  output logic [clt_pkg::CHAR_W-1:0]          out_token_char,
  output logic [clt_pkg::TOK_KIND_W-1:0]      out_token_kind,
  output logic [clt_pkg::POS_OUT_W-1:0]       out_start_line,
  output logic [clt_pkg::POS_OUT_W-1:0]       out_start_column,
  output logic                                out_last_of_run
);

  logic [clt_pkg::RUN_IDX_W-1:0] idx_r;
  logic out_valid_r;
  clt_pkg::event_t ev_r;
  logic last_r;
  logic load;
  logic is_last;

  assign load = !empty && (!out_valid_r || !out_stall);
  assign is_last = ({1'b0, idx_r} + clt_pkg::RUN_CNT_W'(1)) == head.cnt;
  assign pop = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r <= is_last ? '0 : idx_r + clt_pkg::RUN_IDX_W'(1);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r <= head.ev[idx_r];
      last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_event_kind = ev_r.event_kind;
  assign out_token_char = ev_r.token_char;
  assign out_token_kind = ev_r.token_kind;
  assign out_start_line = ev_r.start_line;
  assign out_start_column = ev_r.start_column;
  assign out_last_of_run = last_r;

endmodule

// File: design/c_token_lexer_core.sv
// C token lexer. The input channel carries one source character per item on
// in_char_code. The result channel carries lexer events: a character appended
// to the open token, a token closed, or a lexer error, each with the token kind
// and the line and column where the token began. One input item yields zero to
// four result items, and out_last_of_run marks the final one of each input.
// The front end takes one character per cycle while the queue is not full and
// decides all its events in that cycle. The events wait in a small queue of
// runs and the back end sends them out one per cycle from a registered output
// stage while the receiver does not stall. Input throughput is one character
// per cycle while each character yields at most one event, and the output
// port, at one event per cycle, sets the rate otherwise. A stalled receiver
// holds the output register; the queue keeps accepting characters until it is
// full, and then in_stall rises. After reset the lexer is idle at line 1,
// column 1 with the queue empty. After an error the lexer accepts and drops
// every character until the next reset.
module c_token_lexer_core #(
  parameter int POSITION_WIDTH = clt_pkg::POSITION_WIDTH_DEF,
  parameter int QUEUE_DEPTH = clt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [clt_pkg::CHAR_W-1:0]          in_char_code,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [clt_pkg::EV_KIND_W-1:0]       out_event_kind,
  output logic [clt_pkg::CHAR_W-1:0]          out_token_char,
  output logic [clt_pkg::TOK_KIND_W-1:0]      out_token_kind,
  output logic [clt_pkg::POS_OUT_W-1:0]       out_start_line,
  output logic [clt_pkg::POS_OUT_W-1:0]       out_start_column,
  output logic                                out_last_of_run
);

  logic q_full, q_push, q_pop, q_empty;
  clt_pkg::run_t q_run, q_head;

  clt_front #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_char_code(in_char_code),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_run       (q_run)
  );

  clt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_run(q_run),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  clt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .empty           (q_empty),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_token_char  (out_token_char),
    .out_token_kind  (out_token_kind),
    .out_start_line  (out_start_line),
    .out_start_column(out_start_column),
    .out_last_of_run (out_last_of_run)
  );

  assign in_stall = q_full;

endmodule
